// ===== sv/prct_pkg.sv =====
// Package for the pulse reception collision tracker: constants, codes, beat types.
// No dependencies.
package prct_pkg;

   localparam int TableDepth   = 16;
   localparam int OverheadBits = 16;
   localparam int IdxW         = $clog2(TableDepth);
   localparam int CntW         = $clog2(TableDepth + 1);
   localparam int StampW       = 48;
   localparam int IvlW         = 24;
   localparam int CsrW         = 24;

   localparam logic [1:0] MODE_TX_START = 2'd0;
   localparam logic [1:0] MODE_TX_END   = 2'd1;
   localparam logic [1:0] MODE_RX_START = 2'd2;
   localparam logic [1:0] MODE_RX_END   = 2'd3;

   localparam logic [1:0] PHY_IDLE = 2'd0;
   localparam logic [1:0] PHY_RX   = 2'd1;
   localparam logic [1:0] PHY_TX   = 2'd2;
   localparam logic [1:0] PHY_TXRX = 2'd3;

   localparam logic CSR_IVL   = 1'b0;
   localparam logic CSR_WIDTH = 1'b1;

   typedef struct packed {
      logic [1:0]        mode;
      logic [10:0]       frame_bytes;
      logic [7:0]        sender_id;
      logic [StampW-1:0] start_stamp;
      logic [IvlW-1:0]   sender_interval;
   } req_type;

   typedef struct packed {
      logic [1:0]        phy_mode;
      logic [StampW-1:0] frame_time;
      logic              delivered;
      logic              collided;
      logic              dropped;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;      // capture request, start event
      logic sel_entry; // read entry at walk index
      logic div_start;
      logic finish;    // compose response
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic       need_walk;
      logic       entry_live;
      logic       need_div;
      logic       div_done;
   } sts_type;

endpackage

// ===== sv/prct_ctrl.sv =====
// Controller for the collision tracker: sequences the table walk and divider.
// Depends on prct_pkg.
module prct_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  prct_pkg::sts_type sts,
   output prct_pkg::cmd_type cmd,
   output logic [prct_pkg::IdxW-1:0] walk_idx
);
   import prct_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_DECIDE, S_READ, S_TEST, S_DIV, S_DONE, S_OUT
   } state_type;

   state_type           state_ff, state_in;
   logic [IdxW-1:0]     idx_ff, idx_in;
   logic                rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign walk_idx  = idx_ff;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            idx_in   = '0;
            state_in = sts.need_walk ? S_READ : S_DONE;
         end
         S_READ: begin
            cmd.sel_entry = 1'b1;
            state_in      = S_TEST;
         end
         S_TEST: begin
            if (sts.entry_live && sts.need_div) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else if (idx_ff == IdxW'(TableDepth - 1)) begin
               state_in = S_DONE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_READ;
            end
         end
         S_DIV: begin
            if (sts.div_done) begin
               if (idx_ff == IdxW'(TableDepth - 1)) begin
                  state_in = S_DONE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_READ;
               end
            end
         end
         S_DONE: begin
            cmd.finish   = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_OUT;
         end
         S_OUT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_rsp_only_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == S_OUT) else $error("rsp valid outside output state");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !cmd.load) else $error("load while busy");
   a_done_to_out: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE |=> rsp_valid_ff) else $error("done without response");

endmodule

// ===== sv/prct_div.sv =====
// Serial restoring remainder unit: 48-bit dividend by 24-bit divisor, one bit a cycle.
// Depends on prct_pkg.
module prct_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [prct_pkg::StampW-1:0] dividend,
   input  logic [prct_pkg::IvlW-1:0]   divisor,
   output logic                        done,
   output logic                        zero_rem
);
   import prct_pkg::*;

   localparam int BitW = $clog2(StampW + 1);

   logic [StampW-1:0] num_ff, num_in;
   logic [IvlW:0]     rem_ff, rem_in;
   logic [IvlW-1:0]   dsr_ff, dsr_in;
   logic [BitW-1:0]   cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [IvlW:0]     shifted;
   logic [IvlW+1:0]   diff;

   assign shifted = {rem_ff[IvlW-1:0], num_ff[StampW-1]};
   assign diff    = {1'b0, shifted} - {2'b00, dsr_ff};

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = BitW'(StampW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[StampW-2:0], 1'b0};
         rem_in = diff[IvlW+1] ? shifted : diff[IvlW:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == BitW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign zero_rem = (rem_ff == '0);

endmodule

// ===== sv/prct_dp.sv =====
// Datapath for the collision tracker: entry table, link state, frame time, divider.
// Depends on prct_pkg and prct_div.
module prct_dp (
   input  logic                      clock,
   input  logic                      reset,
   input  prct_pkg::req_type         req_data,
   input  logic                      csr_write,
   input  logic                      csr_index,
   input  logic [prct_pkg::CsrW-1:0] csr_data,
   input  prct_pkg::cmd_type         cmd,
   input  logic [prct_pkg::IdxW-1:0] walk_idx,
   output prct_pkg::sts_type         sts,
   output prct_pkg::rsp_type         rsp_data
);
   import prct_pkg::*;

   logic [CsrW-1:0]   ivl_ff, wid_ff;
   req_type           req_ff;
   logic [1:0]        link_ff, link_in;
   logic [TableDepth-1:0] valid_ff, valid_in;
   logic [TableDepth-1:0] clean_ff, clean_in;
   logic [7:0]        sender_mem [TableDepth];
   logic [StampW-1:0] start_mem  [TableDepth];
   logic [IvlW-1:0]   ivl_mem    [TableDepth];
   logic [7:0]        e_sender_ff;
   logic [StampW-1:0] e_start_ff;
   logic [IvlW-1:0]   e_ivl_ff;
   logic              e_valid_ff;
   logic              hit_ff, hit_in;
   logic              drop_ff, drop_in;
   logic              walk_ff, walk_in;
   logic [StampW-1:0] ftime_ff, ftime_in;
   logic [StampW-1:0] prod_ff;
   rsp_type           rsp_ff;
   logic [CntW-1:0]   nvalid;
   logic              have_free;
   logic [IdxW-1:0]   free_idx;
   logic [StampW-1:0] span;
   logic              div_done, zero_rem;
   logic [14:0]       mult_a;

   always_comb begin
      nvalid    = '0;
      have_free = 1'b0;
      free_idx  = '0;
      for (int i = TableDepth - 1; i >= 0; i--) begin
         nvalid = nvalid + CntW'(valid_ff[i]);
         if (!valid_ff[i]) begin
            have_free = 1'b1;
            free_idx  = IdxW'(i);
         end
      end
   end

   // bytes*8 + overhead - 1 fits in 15 bits at the fixed field width
   assign mult_a = {1'b0, req_ff.frame_bytes, 3'b000} + 15'(OverheadBits - 1);
   assign span   = (e_start_ff > req_ff.start_stamp) ? e_start_ff - req_ff.start_stamp
                                                     : req_ff.start_stamp - e_start_ff;

   prct_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (span),
      .divisor  (e_ivl_ff),
      .done     (div_done),
      .zero_rem (zero_rem)
   );

   assign sts.need_walk  = walk_ff;
   assign sts.entry_live = e_valid_ff && (e_sender_ff != req_ff.sender_id);
   assign sts.need_div   = (e_start_ff != req_ff.start_stamp) && (e_ivl_ff != '0);
   assign sts.div_done   = div_done;
   assign rsp_data       = rsp_ff;

   always_comb begin
      link_in  = link_ff;
      valid_in = valid_ff;
      clean_in = clean_ff;
      hit_in   = hit_ff;
      drop_in  = drop_ff;
      walk_in  = walk_ff;
      ftime_in = ftime_ff;
      if (cmd.load) begin
         hit_in   = 1'b0;
         drop_in  = 1'b0;
         walk_in  = 1'b0;
         ftime_in = '0;
         case (req_data.mode)
            MODE_TX_START: begin
               if (link_ff == PHY_IDLE) link_in = PHY_TX;
               else if (link_ff == PHY_RX) link_in = PHY_TXRX;
            end
            MODE_TX_END: link_in = (nvalid == '0) ? PHY_IDLE : PHY_RX;
            MODE_RX_START: begin
               if (!have_free) begin
                  drop_in = 1'b1;
               end else begin
                  valid_in[free_idx] = 1'b1;
                  clean_in[free_idx] = 1'b1;
                  if (link_ff == PHY_IDLE) link_in = PHY_RX;
                  else if (link_ff == PHY_TX) link_in = PHY_TXRX;
               end
            end
            MODE_RX_END: begin
               if (nvalid == CntW'(1)) begin
                  for (int i = 0; i < TableDepth; i++) begin
                     if (valid_ff[i]) hit_in = !clean_ff[i];
                  end
                  valid_in = '0;
               end else begin
                  walk_in = 1'b1;
                  for (int i = 0; i < TableDepth; i++) begin
                     if (valid_ff[i] && sender_mem[i] == req_data.sender_id) begin
                        valid_in[i] = 1'b0;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
      if (walk_ff && !cmd.load) begin
         // sender removal already done at load; entry_live repeats it harmlessly
         if (sts.entry_live && !sts.need_div && cmd.div_start == 1'b0 &&
             e_start_ff == req_ff.start_stamp && !cmd.sel_entry && !div_done) begin
            hit_in             = 1'b1;
            clean_in[walk_idx] = 1'b0;
         end
         if (div_done && zero_rem) begin
            hit_in             = 1'b1;
            clean_in[walk_idx] = 1'b0;
         end
      end
      if (cmd.finish) begin
         if (req_ff.mode == MODE_TX_START) ftime_in = prod_ff + StampW'(wid_ff);
         if (req_ff.mode == MODE_RX_END && nvalid == '0) begin
            link_in = (link_ff == PHY_TXRX) ? PHY_TX : PHY_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ivl_ff   <= CsrW'(10000);
         wid_ff   <= CsrW'(100);
         link_ff  <= PHY_IDLE;
         valid_ff <= '0;
         walk_ff  <= 1'b0;
      end else begin
         if (csr_write && csr_index == CSR_IVL)   ivl_ff <= csr_data;
         if (csr_write && csr_index == CSR_WIDTH) wid_ff <= csr_data;
         link_ff  <= link_in;
         valid_ff <= valid_in;
         walk_ff  <= cmd.finish ? 1'b0 : walk_in;
      end
      clean_ff <= clean_in;
      hit_ff   <= hit_in;
      drop_ff  <= drop_in;
      ftime_ff <= ftime_in;
      if (cmd.load) req_ff <= req_data;
      prod_ff <= StampW'(mult_a * ivl_ff);
      if (cmd.load && req_data.mode == MODE_RX_START && have_free) begin
         sender_mem[free_idx] <= req_data.sender_id;
         start_mem[free_idx]  <= req_data.start_stamp;
         ivl_mem[free_idx]    <= req_data.sender_interval;
      end
      if (cmd.sel_entry) begin
         e_sender_ff <= sender_mem[walk_idx];
         e_start_ff  <= start_mem[walk_idx];
         e_ivl_ff    <= ivl_mem[walk_idx];
         e_valid_ff  <= valid_ff[walk_idx];
      end else if (cmd.load) begin
         // no stale entry is seen before the first read of a walk
         e_valid_ff  <= 1'b0;
      end
      if (cmd.finish) begin
         rsp_ff.phy_mode   <= link_in;
         rsp_ff.frame_time <= ftime_in;
         rsp_ff.delivered  <= (req_ff.mode == MODE_RX_END) && !hit_ff;
         rsp_ff.collided   <= (req_ff.mode == MODE_RX_END) && hit_ff;
         rsp_ff.dropped    <= drop_ff;
      end
   end

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(rsp_ff.delivered && rsp_ff.collided) || $isunknown(rsp_ff)) else $error("both flags");
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      drop_in && cmd.load |-> valid_ff == '1) else $error("drop with free slot");
   a_txrx_cleared: assert property (@(posedge clock) disable iff (reset)
      cmd.load && req_data.mode == MODE_RX_END && nvalid == CntW'(1) |=> valid_ff == '0)
      else $error("single entry not cleared");

endmodule

// ===== sv/pulse_reception_collision_tracker.sv =====
// Pulse reception collision tracker, top level.
// Beats with no table walk (transmit, start reception, end reception on one entry) go
// from acceptance through the decide and done states to the registered response.
// Other end receptions walk the 16-entry table, a read and a test state an entry plus
// a serial remainder where needed, before the response. One beat at a time.
// Synchronous active-high reset empties the table, sets link idle, restores CSRs.
// Depends on prct_pkg, prct_ctrl, prct_dp.
module pulse_reception_collision_tracker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  prct_pkg::req_type         req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output prct_pkg::rsp_type         rsp_data,
   input  logic                      csr_write,
   input  logic                      csr_index,
   input  logic [prct_pkg::CsrW-1:0] csr_data
);
   import prct_pkg::*;

   cmd_type         cmd;
   sts_type         sts;
   logic [IdxW-1:0] walk_idx;

   prct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd),
      .walk_idx  (walk_idx)
   );

   prct_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .walk_idx  (walk_idx),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

endmodule
